// File: design/mfld_pkg.sv
// Shared types and constants for the monochrome framebuffer line-draw block.
package mfld_pkg;

   // Request kinds carried on the request tuser field.
   localparam logic [1:0] REQ_LINE = 2'd0;
   localparam logic [1:0] REQ_FILL = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   localparam logic [7:0] FILL_BLACK = 8'h00;
   localparam logic [7:0] FILL_WHITE = 8'hFF;

   // Controller states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_END_RD,
      ST_END_WR,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_LOOP,
      ST_READ,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;   // capture the accepted request
      logic pix_rd;     // read the byte under a pixel
      logic pt_end;     // pixel is the line end point, not the walking point
      logic pix_wr;     // write the modified byte back
      logic step;       // advance the walking point one Bresenham step
      logic sweep_wr;   // write the sweep counter address
      logic sweep_zero; // sweep writes zeros (reset clear) instead of fill value
      logic idx_rd;     // read the byte at the request read index
      logic rsp_load;   // load the response register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] kind;
      logic       at_end;
      logic       cnt_last;
   } sts_type;

endpackage

// File: design/mfld_ctrl.sv
// Controller state machine for the framebuffer line-draw block.
module mfld_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  mfld_pkg::sts_type sts,
   output mfld_pkg::cmd_type cmd
);

   mfld_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                rsp_free;

   assign accept   = req_tvalid && (state_ff == mfld_pkg::ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfld_pkg::ST_CLEAR: begin
            if (sts.cnt_last) state_in = mfld_pkg::ST_IDLE;
         end
         mfld_pkg::ST_IDLE: begin
            if (accept) begin
               case (sts.kind)
                  mfld_pkg::REQ_LINE: state_in = mfld_pkg::ST_END_RD;
                  mfld_pkg::REQ_FILL: state_in = mfld_pkg::ST_FILL;
                  mfld_pkg::REQ_READ: state_in = mfld_pkg::ST_READ;
                  default:            state_in = mfld_pkg::ST_RESP;
               endcase
            end
         end
         mfld_pkg::ST_FILL: begin
            if (sts.cnt_last) state_in = mfld_pkg::ST_RESP;
         end
         mfld_pkg::ST_END_RD: state_in = mfld_pkg::ST_END_WR;
         mfld_pkg::ST_END_WR: state_in = mfld_pkg::ST_LOOP;
         mfld_pkg::ST_PIX_RD: state_in = mfld_pkg::ST_PIX_WR;
         mfld_pkg::ST_PIX_WR: state_in = mfld_pkg::ST_LOOP;
         mfld_pkg::ST_LOOP: begin
            state_in = sts.at_end ? mfld_pkg::ST_RESP : mfld_pkg::ST_PIX_RD;
         end
         mfld_pkg::ST_READ: state_in = mfld_pkg::ST_RESP;
         mfld_pkg::ST_RESP: begin
            if (rsp_free) state_in = mfld_pkg::ST_IDLE;
         end
         default: state_in = mfld_pkg::ST_IDLE;
      endcase
   end

   // Output logic: one command set per state.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         mfld_pkg::ST_CLEAR: begin
            cmd.sweep_wr   = 1'b1;
            cmd.sweep_zero = 1'b1;
         end
         mfld_pkg::ST_IDLE:   cmd.load_req = accept;
         mfld_pkg::ST_FILL:   cmd.sweep_wr = 1'b1;
         mfld_pkg::ST_END_RD: begin
            cmd.pix_rd = 1'b1;
            cmd.pt_end = 1'b1;
         end
         mfld_pkg::ST_END_WR: cmd.pix_wr = 1'b1;
         mfld_pkg::ST_PIX_RD: cmd.pix_rd = 1'b1;
         mfld_pkg::ST_PIX_WR: begin
            cmd.pix_wr = 1'b1;
            cmd.step   = 1'b1;
         end
         mfld_pkg::ST_LOOP:   cmd = '0;
         mfld_pkg::ST_READ:   cmd.idx_rd = 1'b1;
         mfld_pkg::ST_RESP:   cmd.rsp_load = rsp_free;
         default:             cmd = '0;
      endcase
   end

   // Response valid flag: set on load, cleared when the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load)     rsp_valid_in = 1'b1;
      else if (rsp_tready)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfld_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == mfld_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: design/mfld_datapath.sv
// Datapath: frame store memory, Bresenham stepper, sweep counter and response register.
module mfld_datapath #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        req_type,
   input  logic [7:0]        x_start,
   input  logic [7:0]        y_start,
   input  logic [7:0]        x_end,
   input  logic [7:0]        y_end,
   input  logic              colour,
   input  logic [9:0]        read_index,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  mfld_pkg::cmd_type cmd,
   output mfld_pkg::sts_type sts,
   output logic [7:0]        read_data,
   output logic [1:0]        done_type
);

   localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
   localparam int ADDR_W      = $clog2(STORE_BYTES);

   logic [7:0]        mem [STORE_BYTES];
   logic [7:0]        rd_data_ff;

   logic              invert_ff;
   logic [1:0]        kind_ff;
   logic              white_ff;
   logic [7:0]        fill_ff;
   logic [9:0]        ridx_ff;
   logic [7:0]        cur_x_ff, cur_y_ff, end_x_ff, end_y_ff;
   logic [7:0]        dx_ff, dy_ff;
   logic              sx_neg_ff, sy_neg_ff;
   logic signed [10:0] err_ff;
   logic [ADDR_W-1:0] cnt_ff;

   logic [ADDR_W-1:0] pix_addr_ff;
   logic [7:0]        pix_mask_ff;
   logic              pix_ok_ff;

   logic [7:0]        rsp_data_ff;
   logic [1:0]        rsp_type_ff;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset)          invert_ff <= 1'b0;
      else if (csr_wr_en) invert_ff <= csr_wr_data;
   end

   // Setup values for a new line.
   logic [7:0]         dx_in, dy_in;
   logic signed [10:0] err_init;
   assign dx_in    = (x_end > x_start) ? (x_end - x_start) : (x_start - x_end);
   assign dy_in    = (y_end > y_start) ? (y_end - y_start) : (y_start - y_end);
   assign err_init = $signed({3'b000, dx_in}) - $signed({3'b000, dy_in});

   // One Bresenham step of the walking point.
   logic signed [11:0] e2, dx_s, dy_s, err_next;
   logic               move_x, move_y;
   assign e2       = {err_ff, 1'b0};
   assign dx_s     = $signed({4'b0000, dx_ff});
   assign dy_s     = $signed({4'b0000, dy_ff});
   assign move_x   = e2 > -dy_s;
   assign move_y   = e2 < dx_s;
   assign err_next = $signed({err_ff[10], err_ff}) - (move_x ? dy_s : 12'sd0)
                     + (move_y ? dx_s : 12'sd0);

   // Request capture and line stepping.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff   <= req_type;
         white_ff  <= colour ^ invert_ff;
         fill_ff   <= colour ? mfld_pkg::FILL_WHITE : mfld_pkg::FILL_BLACK;
         ridx_ff   <= read_index;
         cur_x_ff  <= x_start;
         cur_y_ff  <= y_start;
         end_x_ff  <= x_end;
         end_y_ff  <= y_end;
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         sx_neg_ff <= !(x_start < x_end);
         sy_neg_ff <= !(y_start < y_end);
         err_ff    <= err_init;
      end else if (cmd.step) begin
         err_ff <= err_next[10:0];
         if (move_x) cur_x_ff <= sx_neg_ff ? cur_x_ff - 8'd1 : cur_x_ff + 8'd1;
         if (move_y) cur_y_ff <= sy_neg_ff ? cur_y_ff - 8'd1 : cur_y_ff + 8'd1;
      end
   end

   // Sweep counter for the reset clear and for fills.
   always_ff @(posedge clock) begin
      if (reset || cmd.load_req) cnt_ff <= '0;
      else if (cmd.sweep_wr)     cnt_ff <= cnt_ff + 1'b1;
   end

   // Pixel address, mask and clipping.
   logic [7:0]        px, py;
   logic              pix_ok;
   logic [ADDR_W-1:0] pix_addr;
   assign px       = cmd.pt_end ? end_x_ff : cur_x_ff;
   assign py       = cmd.pt_end ? end_y_ff : cur_y_ff;
   assign pix_ok   = (32'(px) < SCREEN_WIDTH) && (32'(py) < SCREEN_HEIGHT);
   assign pix_addr = ADDR_W'(32'(px) + 32'(py[7:3]) * SCREEN_WIDTH);

   always_ff @(posedge clock) begin
      if (cmd.pix_rd) begin
         pix_addr_ff <= pix_addr;
         pix_mask_ff <= 8'd1 << py[2:0];
         pix_ok_ff   <= pix_ok;
      end
   end

   // Memory read port with registered data.
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              ridx_ok;
   assign ridx_ok = 32'(ridx_ff) < STORE_BYTES;
   assign rd_en   = (cmd.pix_rd && pix_ok) || (cmd.idx_rd && ridx_ok);
   assign rd_addr = cmd.pix_rd ? pix_addr : ADDR_W'(ridx_ff);

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // Memory write port: sweep or pixel read-modify-write.
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data, pix_byte;
   assign pix_byte = white_ff ? (rd_data_ff | pix_mask_ff) : (rd_data_ff & ~pix_mask_ff);
   assign wr_en    = cmd.sweep_wr || (cmd.pix_wr && pix_ok_ff);
   assign wr_addr  = cmd.sweep_wr ? cnt_ff : pix_addr_ff;
   assign wr_data  = cmd.sweep_wr ? (cmd.sweep_zero ? mfld_pkg::FILL_BLACK : fill_ff)
                                  : pix_byte;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= (kind_ff == mfld_pkg::REQ_READ && ridx_ok) ? rd_data_ff : 8'd0;
         rsp_type_ff <= kind_ff;
      end
   end

   // Status back to the controller; the kind comes straight from the port while a request is accepted.
   assign sts.kind     = cmd.load_req ? req_type : kind_ff;
   assign sts.at_end   = (cur_x_ff == end_x_ff) && (cur_y_ff == end_y_ff);
   assign sts.cnt_last = (32'(cnt_ff) == STORE_BYTES - 1);

   assign read_data = rsp_data_ff;
   assign done_type = rsp_type_ff;

endmodule

// File: design/mono_framebuffer_line_draw.sv
// Top level of the monochrome page framebuffer with Bresenham line drawing.
//
// Requests arrive on the req_ stream: tuser carries the request kind (0 draw line,
// 1 fill screen, 2 read byte) and tdata the coordinates, colour and read index.
// Each request yields one response on the rsp_ stream with the read byte in tdata
// (zero for non-read requests and out-of-range reads) and the echoed kind in tuser.
// The csr_ port writes the invert register, which flips line pixel colours.
// A read fetches its byte through the registered read port, a fill writes
// SCREEN_WIDTH*ceil(SCREEN_HEIGHT/8) bytes (one byte written per cycle),
// and a line draws its end point and then each walking point: every pixel is a read and a
// write-back through the frame store's separate read and write ports, plus a loop check.
// One request is in flight at a time; req_tready is high only while idle.
// After reset the store is swept to zero, one byte per cycle, across all
// SCREEN_WIDTH*ceil(SCREEN_HEIGHT/8) bytes (1024 at the default size) before
// the first request is taken; the invert register resets to 0.
// The response sits in an output register, so a new request is accepted while
// it waits; if the receiver stalls, the next response is held until the slot frees.
module mono_framebuffer_line_draw #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // x_start[7:0], y_start[15:8], x_end[23:16], y_end[31:24], colour[32],
   // read_index[42:33], zero fill [47:43]
   input  logic [47:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0]
   output logic [7:0]  rsp_tdata,
   // done_type[1:0]
   output logic [1:0]  rsp_tuser,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   mfld_pkg::cmd_type cmd;
   mfld_pkg::sts_type sts;

   mfld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mfld_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_type    (req_tuser),
      .x_start     (req_tdata[7:0]),
      .y_start     (req_tdata[15:8]),
      .x_end       (req_tdata[23:16]),
      .y_end       (req_tdata[31:24]),
      .colour      (req_tdata[32]),
      .read_index  (req_tdata[42:33]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .read_data   (rsp_tdata),
      .done_type   (rsp_tuser)
   );

endmodule
